>>> hw/rtl/lcd_seq_pkg.sv
// ----------------------------------------------------------------------------
// lcd_seq_pkg
// shared types, constants and tables for the character lcd nibble sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package lcd_seq_pkg;

  // most decimal digits printed for a number word
  localparam int MAX_DIGITS = 5;

  localparam int INIT_BYTES_N = 9;
  localparam int MAX_BYTES    = (MAX_DIGITS + 1 > INIT_BYTES_N) ? MAX_DIGITS + 1 : INIT_BYTES_N;
  localparam int BYTE_W       = $clog2(MAX_BYTES);
  localparam int CNT_W        = $clog2(MAX_DIGITS + 1);
  localparam int DIG_IDX_W    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  localparam logic [7:0] CH_ZERO = 8'h30;

  // reciprocal of ten, exact for 16-bit operands after a shift of 19
  localparam logic [15:0] RECIP_TEN = 16'hCCCD;
  localparam int          RECIP_SH  = 19;

  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_CMD  = 2'd1,
    OP_DATA = 2'd2,
    OP_NUM  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic conv;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic last_step;
  } dp_status_t;

  localparam logic [7:0] INIT_BYTES [INIT_BYTES_N] = '{
    8'h03, 8'h03, 8'h03, 8'h02, 8'h28, 8'h08, 8'h01, 8'h06, 8'h0C
  };

  // extra hold on the final enable-low step of each init byte
  localparam logic [4:0] INIT_EXTRA [INIT_BYTES_N] = '{
    5'd4, 5'd4, 5'd4, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd20
  };

endpackage

`default_nettype wire

>>> hw/rtl/lcd_seq_if.sv
// ----------------------------------------------------------------------------
// lcd_seq_if
// valid/ready channels for command words in and pin-step words out
// ----------------------------------------------------------------------------
`default_nettype none

interface lcd_seq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface lcd_seq_out_if;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic [3:0] data_nibble;
  logic       enable_level;
  logic [4:0] hold_ms;
  logic       last;

  modport source (output valid, output reg_select, output data_nibble,
                  output enable_level, output hold_ms, output last, input ready);
  modport sink   (input valid, input reg_select, input data_nibble,
                  input enable_level, input hold_ms, input last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/char_lcd_nibble_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// 4-bit character lcd driver: turns command words into timed pin-step words
// ----------------------------------------------------------------------------
// timing: init/command/data words give the first pin step in the cycle after
//   accept; a number first divides by ten, one digit (1..MAX_DIGITS) per cycle
// throughput: one pin step per cycle while the sink is ready; init gives 36
//   steps, command/data 4, number 4 per digit; a new word is taken only
//   after the last step of the previous one is delivered
// reset: rst (sync, active high) returns the controller to idle; datapath
//   registers are loaded on accept and need no reset
`default_nettype none

module char_lcd_nibble_sequencer (
  input wire logic     clk,
  input wire logic     rst,
  lcd_seq_in_if.sink   cmd_in,
  lcd_seq_out_if.source pin_out
);
  import lcd_seq_pkg::*;

  // command and status between controller and datapath
  dp_cmd_t    cmd;
  dp_status_t status;

  // controller: idle / digit conversion / step emission
  lcd_seq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd_in.valid),
    .in_is_num (cmd_in.opcode == OP_NUM),
    .in_ready  (cmd_in.ready),
    .out_valid (pin_out.valid),
    .out_ready (pin_out.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // datapath: holds the word, digits and step counters; drives the pin word
  lcd_seq_dp u_dp (
    .clk          (clk),
    .in_opcode    (cmd_in.opcode),
    .in_value     (cmd_in.value),
    .cmd          (cmd),
    .status       (status),
    .reg_select   (pin_out.reg_select),
    .data_nibble  (pin_out.data_nibble),
    .enable_level (pin_out.enable_level),
    .hold_ms      (pin_out.hold_ms),
    .last         (pin_out.last)
  );

endmodule

`default_nettype wire

>>> hw/rtl/lcd_seq_ctrl.sv
// ----------------------------------------------------------------------------
// lcd_seq_ctrl
// controller: accepts a word, runs digit conversion, then walks the pin steps
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_seq_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  input  wire logic                    in_is_num,
  output logic                         in_ready,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output lcd_seq_pkg::dp_cmd_t         cmd,
  input  wire lcd_seq_pkg::dp_status_t status
);
  import lcd_seq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = in_is_num ? ST_CONV : ST_EMIT;
        end
      end
      ST_CONV: begin
        if (status.conv_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready && status.last_step) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CONV: begin
        cmd.conv = 1'b1;
      end
      ST_EMIT: begin
        out_valid   = 1'b1;
        cmd.advance = out_ready;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/lcd_seq_dp.sv
// ----------------------------------------------------------------------------
// lcd_seq_dp
// datapath: word registers, decimal digit extraction and pin-step generation
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_seq_dp (
  input  wire logic             clk,
  input  wire logic [1:0]       in_opcode,
  input  wire logic [15:0]      in_value,
  input  wire lcd_seq_pkg::dp_cmd_t cmd,
  output lcd_seq_pkg::dp_status_t   status,
  output logic                  reg_select,
  output logic [3:0]            data_nibble,
  output logic                  enable_level,
  output logic [4:0]            hold_ms,
  output logic                  last
);
  import lcd_seq_pkg::*;

  op_t               op;
  logic [15:0]       val;
  logic [CNT_W-1:0]  cnt;
  logic [BYTE_W-1:0] byte_idx;
  logic [1:0]        step;
  logic [3:0]        dig [MAX_DIGITS];

  // divide by ten through the reciprocal
  logic [31:0]       prod;
  logic [15:0]       quot;
  logic [15:0]       quot_x10;
  logic [3:0]        rem;
  logic [CNT_W-1:0]  cnt_inc;

  assign prod     = 32'(val) * 32'(RECIP_TEN);
  assign quot     = 16'(prod >> RECIP_SH);
  assign quot_x10 = 16'((quot << 3) + (quot << 1));
  assign rem      = 4'(val - quot_x10);
  assign cnt_inc  = CNT_W'(cnt + CNT_W'(1));

  assign status.conv_done = (quot == 16'd0) || (cnt_inc == CNT_W'(MAX_DIGITS));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op       <= op_t'(in_opcode);
      val      <= in_value;
      cnt      <= '0;
      byte_idx <= '0;
      step     <= 2'd0;
    end else if (cmd.conv) begin
      dig[cnt[DIG_IDX_W-1:0]] <= rem;
      cnt <= cnt_inc;
      val <= quot;
    end else if (cmd.advance) begin
      step <= step + 2'd1;
      if (step == 2'd3) begin
        byte_idx <= BYTE_W'(byte_idx + BYTE_W'(1));
      end
    end
  end

  // digits print most significant first
  logic [CNT_W-1:0] dig_sel;
  logic [7:0]       cur_byte;
  logic             last_byte;

  assign dig_sel = CNT_W'(cnt - CNT_W'(1) - CNT_W'(byte_idx));

  always_comb begin
    cur_byte  = 8'h00;
    last_byte = 1'b1;
    case (op)
      OP_INIT: begin
        cur_byte  = INIT_BYTES[byte_idx];
        last_byte = (byte_idx == BYTE_W'(INIT_BYTES_N - 1));
      end
      OP_CMD, OP_DATA: begin
        cur_byte  = val[7:0];
        last_byte = 1'b1;
      end
      OP_NUM: begin
        cur_byte  = CH_ZERO + {4'h0, dig[dig_sel[DIG_IDX_W-1:0]]};
        last_byte = (BYTE_W'(byte_idx + BYTE_W'(1)) == BYTE_W'(cnt));
      end
      default: ;
    endcase
  end

  assign status.last_step = (step == 2'd3) && last_byte;

  assign reg_select   = (op == OP_DATA) || (op == OP_NUM);
  assign data_nibble  = step[1] ? cur_byte[3:0] : cur_byte[7:4];
  assign enable_level = ~step[0];
  assign hold_ms      = ((op == OP_INIT) && (step == 2'd3))
                        ? 5'(5'd1 + INIT_EXTRA[byte_idx]) : 5'd1;
  assign last         = status.last_step;

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the character lcd nibble sequencer: command words go in over a
// valid/ready channel, every pin-step word that comes out is compared field by
// field with a local prediction of the 4-bit lcd bus sequence
// ----------------------------------------------------------------------------

module tb;
  import lcd_seq_pkg::*;

  // run shape
  localparam int RANDOM_WORDS    = 330;
  localparam int CALM_TAIL_WORDS = 40;
  localparam int PHASE_WORDS     = 30;
  localparam int HOLD_OFF_AT     = 30;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 40;
  localparam int CYCLE_LIMIT     = 400000;

  // power-up sequence of the lcd in 4-bit mode and the settle time after each byte
  localparam logic [7:0] POWER_UP_BYTES [9] = '{
    8'h03, 8'h03, 8'h03, 8'h02, 8'h28, 8'h08, 8'h01, 8'h06, 8'h0C
  };
  localparam logic [4:0] POWER_UP_EXTRA_MS [9] = '{
    5'd4, 5'd4, 5'd4, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd20
  };
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  // one pin state on the lcd bus
  typedef struct packed {
    logic       reg_select;
    logic [3:0] data_nibble;
    logic       enable_level;
    logic [4:0] hold_ms;
    logic       last;
  } pin_step_t;

  // directed word; typed_n > 0 means the lcd bytes are spelled out here,
  // least significant byte is the last one sent
  typedef struct packed {
    op_t         op;
    logic [15:0] value;
    logic [2:0]  typed_n;
    logic [39:0] typed_bytes;
  } directed_word_t;

  localparam int DIRECTED_N = 21;
  localparam directed_word_t DIRECTED_WORDS [DIRECTED_N] = '{
    // power-up right after reset
    '{OP_INIT, 16'h0000, 3'd0, 40'h0},
    // command byte extremes, upper byte must be ignored
    '{OP_CMD,  16'h0000, 3'd1, 40'h00},
    '{OP_CMD,  16'hFFFF, 3'd1, 40'hFF},
    '{OP_CMD,  16'h5AA5, 3'd1, 40'hA5},
    // data byte extremes
    '{OP_DATA, 16'h0000, 3'd1, 40'h00},
    '{OP_DATA, 16'hFFFF, 3'd1, 40'hFF},
    '{OP_DATA, 16'hA55A, 3'd0, 40'h0},
    '{OP_DATA, 16'h0041, 3'd1, 40'h41},
    // zero prints a single digit, largest value prints all five
    '{OP_NUM,  16'd0,     3'd1, 40'h30},
    '{OP_NUM,  16'd65535, 3'd5, 40'h36_35_35_33_35},
    '{OP_NUM,  16'd9,     3'd1, 40'h39},
    '{OP_NUM,  16'd10,    3'd2, 40'h31_30},
    '{OP_NUM,  16'd10000, 3'd5, 40'h31_30_30_30_30},
    '{OP_NUM,  16'd1,     3'd1, 40'h31},
    // digit count boundaries
    '{OP_NUM,  16'd99,    3'd0, 40'h0},
    '{OP_NUM,  16'd100,   3'd0, 40'h0},
    '{OP_NUM,  16'd9999,  3'd0, 40'h0},
    '{OP_NUM,  16'd12345, 3'd0, 40'h0},
    '{OP_NUM,  16'd40960, 3'd0, 40'h0},
    // power-up again, value is don't-care
    '{OP_INIT, 16'hFFFF, 3'd0, 40'h0},
    '{OP_CMD,  16'h0001, 3'd0, 40'h0}
  };

  logic clk;
  logic rst;

  lcd_seq_in_if  cmd_if ();
  lcd_seq_out_if pin_if ();

  char_lcd_nibble_sequencer DUT (
    .clk     (clk),
    .rst     (rst),
    .cmd_in  (cmd_if),
    .pin_out (pin_if)
  );

  // pin steps still owed by the block, oldest first
  pin_step_t pin_steps_due[$];

  int errors         = 0;
  int words_accepted = 0;
  int cycle_count    = 0;
  int idle_pct       = 25;
  bit calm_tail      = 1'b0;
  bit hold_off_done  = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // one byte on a 4-bit bus: high nibble then low, each strobed high then low;
  // only the final low strobe carries the extra settle time
  function automatic void queue_lcd_byte(logic rs, logic [7:0] b,
                                         logic [4:0] extra_ms);
    pin_steps_due.push_back('{rs, b[7:4], 1'b1, 5'd1, 1'b0});
    pin_steps_due.push_back('{rs, b[7:4], 1'b0, 5'd1, 1'b0});
    pin_steps_due.push_back('{rs, b[3:0], 1'b1, 5'd1, 1'b0});
    pin_steps_due.push_back('{rs, b[3:0], 1'b0, 5'd1 + extra_ms, 1'b0});
  endfunction

  function automatic void predict_pin_steps(op_t op, logic [15:0] value);
    int unsigned rest;
    int          n_dig;
    logic [3:0]  digits [MAX_DIGITS];
    case (op)
      OP_INIT: begin
        for (int k = 0; k < 9; k++)
          queue_lcd_byte(1'b0, POWER_UP_BYTES[k], POWER_UP_EXTRA_MS[k]);
      end
      OP_CMD: begin
        queue_lcd_byte(1'b0, value[7:0], 5'd0);
      end
      OP_DATA: begin
        queue_lcd_byte(1'b1, value[7:0], 5'd0);
      end
      default: begin
        // decimal, least significant digit first, then sent in reverse
        rest  = 32'(value);
        n_dig = 0;
        do begin
          digits[n_dig] = 4'(rest % 10);
          n_dig++;
          rest = rest / 10;
        end while (rest != 0 && n_dig < MAX_DIGITS);
        for (int k = n_dig - 1; k >= 0; k--)
          queue_lcd_byte(1'b1, ASCII_ZERO + 8'(digits[k]), 5'd0);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // command side: drive at the falling edge, accept at the rising edge
  // ---------------------------------------------------------------------------

  // enters and leaves on a falling edge
  task automatic offer_word(op_t op, logic [15:0] value, logic [2:0] typed_n,
                            logic [39:0] typed_bytes);
    int due_before;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    cmd_if.valid  <= 1'b1;
    cmd_if.opcode <= op;
    cmd_if.value  <= value;
    do @(posedge clk); while (!cmd_if.ready);
    // word taken at this edge
    due_before = pin_steps_due.size();
    if (typed_n != 0) begin
      for (int k = int'(typed_n) - 1; k >= 0; k--)
        queue_lcd_byte(op != OP_CMD, typed_bytes[8*k +: 8], 5'd0);
    end else begin
      predict_pin_steps(op, value);
    end
    if (pin_steps_due.size() > due_before)
      pin_steps_due[pin_steps_due.size() - 1].last = 1'b1;
    words_accepted++;
    @(negedge clk);
  endtask

  initial begin
    op_t         op;
    logic [15:0] value;
    int          sel;
    rst           = 1'b1;
    cmd_if.valid  = 1'b0;
    cmd_if.opcode = OP_INIT;
    cmd_if.value  = 16'h0000;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    for (int i = 0; i < DIRECTED_N; i++)
      offer_word(DIRECTED_WORDS[i].op, DIRECTED_WORDS[i].value,
                 DIRECTED_WORDS[i].typed_n, DIRECTED_WORDS[i].typed_bytes);

    // random words, idling rate changes from phase to phase
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS - CALM_TAIL_WORDS) begin
        idle_pct  = 0;
        calm_tail = 1'b1;
      end else if (!calm_tail && i % PHASE_WORDS == 0) begin
        sel      = $urandom_range(0, 2);
        idle_pct = (sel == 0) ? 0 : (sel == 1) ? 25 : 60;
      end
      sel   = $urandom_range(0, 99);
      value = 16'($urandom);
      if (sel < 4)       op = OP_INIT;
      else if (sel < 34) op = OP_CMD;
      else if (sel < 64) op = OP_DATA;
      else begin
        op = OP_NUM;
        // spread the digit count, most numbers are short
        value = value >> $urandom_range(0, 15);
      end
      offer_word(op, value, 3'd0, 40'h0);
    end
    cmd_if.valid <= 1'b0;

    // drain, then give a stray extra step time to show up
    while (pin_steps_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // pin side: ready bursts, one long hold-off to back the block up
  // ---------------------------------------------------------------------------

  initial begin
    pin_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!hold_off_done && words_accepted >= HOLD_OFF_AT) begin
        // sender keeps offering meanwhile, so the input stalls too
        pin_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_done = 1'b1;
        pin_if.ready <= 1'b1;
      end else if (!calm_tail && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        pin_if.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        pin_if.ready <= 1'b1;
      end else begin
        pin_if.ready <= 1'b1;
      end
    end
  end

  task automatic check_pin_field(string field, int unsigned expv, int unsigned actv);
    if (expv != actv) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, field, expv, actv);
      errors++;
    end
  endtask

  // compare each delivered pin-step word against the oldest one owed
  always @(posedge clk) begin : pin_monitor
    pin_step_t due;
    if (!rst && pin_if.valid && pin_if.ready) begin
      if (pin_steps_due.size() == 0) begin
        $display({"%0t: unexpected pin step, expected none, ",
                  "actual rs=%0d nib=%0h en=%0d hold=%0d last=%0d"},
                 $realtime, pin_if.reg_select, pin_if.data_nibble, pin_if.enable_level,
                 pin_if.hold_ms, pin_if.last);
        errors++;
      end else begin
        due = pin_steps_due.pop_front();
        check_pin_field("reg_select",   32'(due.reg_select),   32'(pin_if.reg_select));
        check_pin_field("data_nibble",  32'(due.data_nibble),  32'(pin_if.data_nibble));
        check_pin_field("enable_level", 32'(due.enable_level), 32'(pin_if.enable_level));
        check_pin_field("hold_ms",      32'(due.hold_ms),      32'(pin_if.hold_ms));
        check_pin_field("last",         32'(due.last),         32'(pin_if.last));
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule

>>> files.f
hw/rtl/lcd_seq_pkg.sv
hw/rtl/lcd_seq_if.sv
hw/rtl/lcd_seq_ctrl.sv
hw/rtl/lcd_seq_dp.sv
hw/rtl/char_lcd_nibble_sequencer.sv
tb/tb.sv
